// ----- sv/rds_group_bit_encoder_macros.svh -----
// assertion macros for the rds group bit encoder
`ifndef RDS_GROUP_BIT_ENCODER_MACROS_SVH
`define RDS_GROUP_BIT_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define RGBE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RGBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBE_ASSERT(lbl, clk, rstn, prop, msg)
`define RGBE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/rgbe_pkg.sv -----
`timescale 1ns / 1ps

package rgbe_pkg;

    localparam int RT_SEGMENTS_DEF = 16;
    localparam int PS_GROUPS       = 4;
    localparam int BITS_PER_GROUP  = 104;
    localparam int BLOCK_BITS      = 26;
    localparam int DATA_BITS       = 16;
    localparam int CHECK_BITS      = 10;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CHECK_BITS-1:0] CHECK_POLY_LOW = 10'h1B9;
    localparam logic [31:0]           SPACES32       = 32'h2020_2020;
    localparam logic [15:0]           RT_GROUP_TYPE  = 16'h2000;
    localparam logic [15:0]           PI_RESET       = 16'hFFFF;
    localparam logic [63:0]           PS_RESET       = 64'h2020_2020_2020_2020;

    localparam logic [CHECK_BITS-1:0] OFFSET_WORDS [4] = '{10'h0FC, 10'h198, 10'h168, 10'h1B4};

    localparam logic [CFG_IDX_W-1:0] CFG_PI_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PS_TEXT = 2'd1;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  rt_index;
        logic [31:0] rt_word;
    } t_in_word;

    typedef struct packed {
        logic       chip_level;
        logic       data_bit;
        logic [4:0] group_number;
        logic [6:0] bit_number;
    } t_out_word;

    // remainder of data * x^10 by the block check polynomial
    function automatic logic [CHECK_BITS-1:0] checkword(input logic [DATA_BITS-1:0] data);
        logic [CHECK_BITS-1:0] rem;
        logic                  fb;
        rem = '0;
        for (int i = DATA_BITS - 1; i >= 0; i--) begin
            fb  = rem[CHECK_BITS-1] ^ data[i];
            rem = {rem[CHECK_BITS-2:0], 1'b0};
            if (fb) begin
                rem = rem ^ CHECK_POLY_LOW;
            end
        end
        return rem;
    endfunction

endpackage

// ----- sv/rds_group_bit_encoder.sv -----
`timescale 1ns / 1ps
`include "rds_group_bit_encoder_macros.svh"
// rds group bit encoder
// input channel (i_in_valid / o_in_ready / i_in_word): a tick word asks for the
// next bit of the rotating group sequence, a load word writes one radiotext
// segment of four characters into the store.
// output channel (o_out_valid / i_out_ready / o_out_word): one word per tick,
// carrying raw bit, differential level, group and bit position. loads give none.
// configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; index 0 is the pi code, index 1 the eight ps characters.
// an accepted tick word is registered in the output register, or in the skid stage.
// throughput: one word per cycle while o_in_ready is high; the bit, its 10-bit
// checkword and the level are formed in one pass from the counters between the
// input port and the output register.
// a skid stage behind the output register lets one more word in while the
// receiver stalls; ready drops only when both are full.
// reset: counters and level to zero, pi code to ffff, ps and radiotext to spaces,
// output and skid stages empty. no clearing pass is needed.
module rds_group_bit_encoder #(
    parameter int RT_SEGMENTS = rgbe_pkg::RT_SEGMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rgbe_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rgbe_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rgbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);
    import rgbe_pkg::*;

    localparam int SEG_W        = (RT_SEGMENTS > 1) ? $clog2(RT_SEGMENTS) : 1;
    localparam int TOTAL_GROUPS = PS_GROUPS + RT_SEGMENTS;

    logic [15:0]            r_pi_code;
    logic [63:0]            r_ps_text;
    logic [4:0]             r_group;
    logic [6:0]             r_bit;
    logic                   r_level;
    logic [31:0]            r_rt_store [RT_SEGMENTS];
    logic [RT_SEGMENTS-1:0] r_rt_valid;

    logic      r_out_valid;
    t_out_word r_out;
    logic      r_skid_valid;
    t_out_word r_skid;

    logic            tick_acc;
    logic            load_acc;
    logic            pop;
    logic [1:0]      blk;
    logic [4:0]      off;
    logic [SEG_W-1:0] seg;
    logic [31:0]     rt_word_rd;
    logic [15:0]     data;
    logic [CHECK_BITS-1:0] chk;
    logic            bit_val;
    logic [4:0]      n_group;
    logic [6:0]      n_bit;
    t_out_word       res;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign tick_acc = i_in_valid && o_in_ready && (i_in_word.req_type == REQ_TICK);
    assign load_acc = i_in_valid && o_in_ready && (i_in_word.req_type == REQ_LOAD);
    assign pop      = r_out_valid && i_out_ready;

    // block and offset within the group
    always_comb begin
        if (r_bit < 7'(BLOCK_BITS)) begin
            blk = 2'd0;
            off = 5'(r_bit);
        end else if (r_bit < 7'(2 * BLOCK_BITS)) begin
            blk = 2'd1;
            off = 5'(r_bit - 7'(BLOCK_BITS));
        end else if (r_bit < 7'(3 * BLOCK_BITS)) begin
            blk = 2'd2;
            off = 5'(r_bit - 7'(2 * BLOCK_BITS));
        end else begin
            blk = 2'd3;
            off = 5'(r_bit - 7'(3 * BLOCK_BITS));
        end
    end

    assign seg        = SEG_W'(r_group - 5'(PS_GROUPS));
    assign rt_word_rd = r_rt_valid[seg] ? r_rt_store[seg] : SPACES32;

    always_comb begin
        data = r_pi_code;
        if (r_group < 5'(PS_GROUPS)) begin
            case (blk)
                2'd1: data = 16'(r_group);
                2'd2: begin
                    case (r_group[1:0])
                        2'd0:    data = r_ps_text[63:48];
                        2'd1:    data = r_ps_text[47:32];
                        2'd2:    data = r_ps_text[31:16];
                        default: data = r_ps_text[15:0];
                    endcase
                end
                default: data = r_pi_code;
            endcase
        end else begin
            case (blk)
                2'd1:    data = RT_GROUP_TYPE | 16'(seg);
                2'd2:    data = rt_word_rd[31:16];
                2'd3:    data = rt_word_rd[15:0];
                default: data = r_pi_code;
            endcase
        end
    end

    assign chk = checkword(data) ^ OFFSET_WORDS[blk];

    always_comb begin
        if (off < 5'(DATA_BITS)) begin
            bit_val = data[4'(5'(DATA_BITS - 1) - off)];
        end else begin
            bit_val = chk[4'(5'(BLOCK_BITS - 1) - off)];
        end
    end

    always_comb begin
        n_bit   = r_bit + 7'd1;
        n_group = r_group;
        if (r_bit == 7'(BITS_PER_GROUP - 1)) begin
            n_bit = '0;
            if (r_group == 5'(TOTAL_GROUPS - 1)) begin
                n_group = '0;
            end else begin
                n_group = r_group + 5'd1;
            end
        end
    end

    always_comb begin
        res.chip_level   = r_level ^ bit_val;
        res.data_bit     = bit_val;
        res.group_number = r_group;
        res.bit_number   = r_bit;
    end

    // sequence state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pi_code  <= PI_RESET;
            r_ps_text  <= PS_RESET;
            r_group    <= '0;
            r_bit      <= '0;
            r_level    <= 1'b0;
            r_rt_valid <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PI_CODE: r_pi_code <= i_cfg_data[15:0];
                    CFG_PS_TEXT: r_ps_text <= i_cfg_data;
                    default: ;
                endcase
            end
            if (tick_acc) begin
                r_group <= n_group;
                r_bit   <= n_bit;
                r_level <= res.chip_level;
            end
            if (load_acc && (5'(i_in_word.rt_index) < 5'(RT_SEGMENTS))) begin
                r_rt_valid[i_in_word.rt_index[SEG_W-1:0]] <= 1'b1;
            end
        end
    end

    // radiotext store
    always_ff @(posedge i_clk) begin
        if (load_acc && (5'(i_in_word.rt_index) < 5'(RT_SEGMENTS))) begin
            r_rt_store[i_in_word.rt_index[SEG_W-1:0]] <= i_in_word.rt_word;
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (tick_acc) begin
                if (!r_out_valid || pop) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `RGBE_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with output empty")
    `RGBE_ASSERT(a_bit_range, i_clk, i_rst_n, r_bit < 7'(BITS_PER_GROUP), "bit counter out of range")
    `RGBE_ASSERT(a_group_range, i_clk, i_rst_n, r_group < 5'(TOTAL_GROUPS), "group counter out of range")
    `RGBE_ASSERT(a_tick_gives_word, i_clk, i_rst_n, tick_acc |=> o_out_valid, "tick word lost")
    `RGBE_ASSERT(a_load_holds_count, i_clk, i_rst_n, load_acc |=> $stable(r_bit) && $stable(r_level), "load moved the sequence")

endmodule
